// ----- hw/rtl/h3126e_pkg.sv -----
package h3126e_pkg;

  // Code geometry.
  localparam int DATA_BITS   = 26;
  localparam int PARITY_BITS = 5;
  localparam int CODE_BITS   = DATA_BITS + PARITY_BITS;

  // Packet framing.
  localparam int PACKET_BYTES = 13;
  localparam int POS_BITS     = 4;
  localparam int COUNT_BITS   = 6;
  localparam int PEND_BITS    = 32;

  typedef logic [DATA_BITS-1:0]   data_t;
  typedef logic [PARITY_BITS-1:0] parity_t;
  typedef logic [CODE_BITS-1:0]   code_t;
  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [PEND_BITS-1:0]   pend_t;

  // Byte positions after which a code word is complete.
  localparam pos_t POS_BLOCK0 = 4'd3;
  localparam pos_t POS_BLOCK1 = 4'd6;
  localparam pos_t POS_BLOCK2 = 4'd9;
  localparam pos_t POS_BLOCK3 = 4'd12;

  // Block numbers within a packet.
  localparam logic [1:0] BLOCK0 = 2'd0;
  localparam logic [1:0] BLOCK1 = 2'd1;
  localparam logic [1:0] BLOCK2 = 2'd2;
  localparam logic [1:0] BLOCK3 = 2'd3;

  // Parity bit 26+k covers the data bits selected by PARITY_MASK[k].
  localparam data_t PARITY_MASK [PARITY_BITS] = '{
    26'd44739931, 26'd53687917, 26'd63162254, 26'd66848752, 26'd67106816
  };

endpackage

// ----- hw/rtl/h3126e_encoder.sv -----
module h3126e_encoder (
  input  h3126e_pkg::data_t data,
  output h3126e_pkg::code_t code
);

  h3126e_pkg::parity_t parity;

  // Each parity bit is an XOR tree over the masked data bits.
  always_comb begin
    for (int k = 0; k < h3126e_pkg::PARITY_BITS; k++) begin
      parity[k] = ^(data & h3126e_pkg::PARITY_MASK[k]);
    end
  end

  assign code = {parity, data};

endmodule

// ----- hw/rtl/hamming_31_26_stream_encoder_core.sv -----
// Hamming (31,26) stream encoder. Bytes arrive on the input channel one byte
// per handshake and are grouped into 13-byte packets, read as one 104-bit
// little-endian number that is cut into four 26-bit blocks. Each block leaves
// as a 31-bit code word with the data in bits 0 to 25 and five parity bits in
// bits 26 to 30, together with its block number and a last flag on the fourth
// word of the packet. A word comes out after the 4th, 7th, 10th and 13th byte;
// the other bytes produce no output. The block takes one byte per clock cycle
// for as long as the output side keeps up. A byte that completes a word is
// first loaded into the input register by the edge that accepts it; a single
// pass of bit packing and parity XOR trees then carries it into the output
// register, where it becomes valid at the output. The input register is
// released whenever the output register is empty or being read in the same
// cycle, so a waiting result stops new bytes only once the input register is
// full too.
module hamming_31_26_stream_encoder_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output h3126e_pkg::code_t      code_word,
  output logic [1:0]             block_index,
  output logic                   last_of_packet
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Packing state: bits received but not yet emitted, oldest in bit 0.
  h3126e_pkg::pend_t  pending_bits;
  h3126e_pkg::count_t pending_count;
  h3126e_pkg::pos_t   byte_position;

  h3126e_pkg::pend_t  pending_bits_next;
  h3126e_pkg::count_t pending_count_next;
  h3126e_pkg::pos_t   byte_position_next;

  logic               s1_advance;
  logic               in_take;
  logic               pos_bad;
  h3126e_pkg::pos_t   pos_eff;
  h3126e_pkg::pos_t   pos_inc;
  h3126e_pkg::pend_t  base_bits;
  h3126e_pkg::count_t base_count;
  h3126e_pkg::pend_t  merged_bits;
  h3126e_pkg::count_t count_sum;
  logic               emit;
  logic               is_last;
  logic [1:0]         block_sel;
  h3126e_pkg::code_t  code_calc;

  // The input register moves on when the output register has room now.
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign in_take    = in_valid && in_ready;

  // A position past the packet end cannot arise from reset, but it is
  // treated as the start of a fresh packet with nothing pending.
  assign pos_bad    = byte_position >= h3126e_pkg::POS_BITS'(h3126e_pkg::PACKET_BYTES);
  assign pos_eff    = pos_bad ? '0 : byte_position;
  assign base_bits  = pos_bad ? '0 : pending_bits;
  assign base_count = pos_bad ? '0 : pending_count;

  // Append the new byte above the pending bits.
  assign merged_bits = base_bits |
                       (h3126e_pkg::PEND_BITS'(s1_byte) << base_count[4:0]);
  assign count_sum   = base_count + h3126e_pkg::COUNT_BITS'(8);
  assign pos_inc     = pos_eff + h3126e_pkg::POS_BITS'(1);

  // Which positions finish a word, and which block that word is.
  always_comb begin
    emit      = 1'b1;
    block_sel = h3126e_pkg::BLOCK0;
    unique case (pos_eff)
      h3126e_pkg::POS_BLOCK0: block_sel = h3126e_pkg::BLOCK0;
      h3126e_pkg::POS_BLOCK1: block_sel = h3126e_pkg::BLOCK1;
      h3126e_pkg::POS_BLOCK2: block_sel = h3126e_pkg::BLOCK2;
      h3126e_pkg::POS_BLOCK3: block_sel = h3126e_pkg::BLOCK3;
      default:                emit      = 1'b0;
    endcase
  end

  assign is_last = pos_eff == h3126e_pkg::POS_BLOCK3;

  h3126e_encoder u_encoder (
    .data (merged_bits[h3126e_pkg::DATA_BITS-1:0]),
    .code (code_calc)
  );

  // Next packing state once the byte in the input register is consumed.
  always_comb begin
    byte_position_next = (pos_inc >= h3126e_pkg::POS_BITS'(h3126e_pkg::PACKET_BYTES)) ?
                         '0 : pos_inc;
    pending_bits_next  = merged_bits;
    pending_count_next = count_sum;
    if (emit) begin
      if (is_last) begin
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else begin
        pending_bits_next  = merged_bits >> h3126e_pkg::DATA_BITS;
        pending_count_next =
          (count_sum >= h3126e_pkg::COUNT_BITS'(h3126e_pkg::DATA_BITS)) ?
          count_sum - h3126e_pkg::COUNT_BITS'(h3126e_pkg::DATA_BITS) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
      byte_position <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && s1_advance) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
        byte_position <= byte_position_next;
      end

      if (s1_valid && s1_advance && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= data_byte;
    end
    if (s1_valid && s1_advance && emit) begin
      code_word      <= code_calc;
      block_index    <= block_sel;
      last_of_packet <= is_last;
    end
  end

  // The last word of a packet is always the fourth block.
  a_last_is_block3: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_packet |-> block_index == h3126e_pkg::BLOCK3)
    else $error("last word not on block 3");

  // A full input register behind a stalled output must hold off new bytes.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && s1_valid |-> !in_ready)
    else $error("byte accepted while pipeline stalled");

  // Finishing a packet leaves the packer empty at position zero.
  a_packet_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance && is_last |=>
      pending_count == '0 && byte_position == '0)
    else $error("packer not cleared at packet end");

  // The pending count never exceeds the pending register.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= h3126e_pkg::COUNT_BITS'(h3126e_pkg::PEND_BITS))
    else $error("pending count out of range");

endmodule
